// File: rtl/ps2_set2_to_hid_report_macros.svh
// assertion helpers shared by the rtl
`ifndef PS2_SET2_TO_HID_REPORT_MACROS_SVH
`define PS2_SET2_TO_HID_REPORT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PS2HID_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ps2hid: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PS2HID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ps2hid: next-cycle check failed");

`endif

// File: rtl/ps2hid_pkg.sv
`default_nettype none

package ps2hid_pkg;

    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int OUT_SLOTS         = 6;
    localparam int TDATA_W           = 8 * (1 + OUT_SLOTS);
    localparam int BASE_LEN          = 132;

    // prefix bytes and the BAT_OK byte of scan set 2
    localparam logic [7:0] CODE_BAT_OK = 8'hAA;
    localparam logic [7:0] CODE_PAUSE  = 8'hE1;
    localparam logic [7:0] CODE_EXT    = 8'hE0;
    localparam logic [7:0] CODE_BREAK  = 8'hF0;

    typedef logic [7:0] usage_t;

    localparam usage_t BASE_MAP [BASE_LEN] = '{
        8'h00, 8'h42, 8'h00, 8'h3E, 8'h3C, 8'h3A, 8'h3B, 8'h45,
        8'h68, 8'h43, 8'h41, 8'h3F, 8'h3D, 8'h2B, 8'h35, 8'h67,
        8'h69, 8'hE2, 8'hE1, 8'h00, 8'hE0, 8'h14, 8'h1E, 8'h00,
        8'h6A, 8'h00, 8'h1D, 8'h16, 8'h04, 8'h1A, 8'h1F, 8'h00,
        8'h6B, 8'h06, 8'h1B, 8'h07, 8'h08, 8'h21, 8'h20, 8'h00,
        8'h6C, 8'h2C, 8'h19, 8'h09, 8'h17, 8'h15, 8'h22, 8'h00,
        8'h6D, 8'h11, 8'h05, 8'h0B, 8'h0A, 8'h1C, 8'h23, 8'h00,
        8'h6E, 8'h00, 8'h10, 8'h0D, 8'h18, 8'h24, 8'h25, 8'h00,
        8'h6F, 8'h36, 8'h0E, 8'h0C, 8'h12, 8'h27, 8'h26, 8'h00,
        8'h70, 8'h37, 8'h38, 8'h0F, 8'h33, 8'h13, 8'h2D, 8'h00,
        8'h71, 8'h00, 8'h34, 8'h00, 8'h2F, 8'h2E, 8'h00, 8'h72,
        8'h39, 8'hE5, 8'h28, 8'h30, 8'h00, 8'h32, 8'h00, 8'h73,
        8'h00, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h00,
        8'h00, 8'h59, 8'h00, 8'h5C, 8'h5F, 8'h00, 8'h00, 8'h00,
        8'h62, 8'h63, 8'h5A, 8'h5D, 8'h5E, 8'h60, 8'h29, 8'h53,
        8'h44, 8'h57, 8'h5B, 8'h56, 8'h55, 8'h61, 8'h47, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h40
    };

    function automatic usage_t map_base(input logic [7:0] code);
        usage_t u;
        u = 8'h00;
        if (code < 8'(BASE_LEN)) begin
            u = BASE_MAP[code];
        end
        return u;
    endfunction

    function automatic usage_t map_extended(input logic [7:0] code);
        usage_t u;
        case (code)
            8'h11: u = 8'hE6;
            8'h1F: u = 8'hE3;
            8'h14: u = 8'hE4;
            8'h27: u = 8'hE7;
            8'h4A: u = 8'h54;
            8'h5A: u = 8'h58;
            8'h69: u = 8'h4D;
            8'h6B: u = 8'h50;
            8'h6C: u = 8'h4A;
            8'h7C: u = 8'h46;
            8'h70: u = 8'h49;
            8'h71: u = 8'h4C;
            8'h72: u = 8'h51;
            8'h74: u = 8'h4F;
            8'h75: u = 8'h52;
            8'h7A: u = 8'h4E;
            8'h7D: u = 8'h4B;
            default: u = 8'h00;
        endcase
        return u;
    endfunction

    // usages E0..E7 are the eight modifier keys
    function automatic logic [7:0] modifier_bit(input usage_t u);
        logic [7:0] m;
        m = 8'h00;
        if (u[7:3] == 5'b11100) begin
            m = 8'h01 << u[2:0];
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ps2_set2_to_hid_report.sv
// channel | dir | tdata fields, lowest bit up                    | tuser
// s_axis  | in  | scan_byte[7:0]                                 | flush
// m_axis  | out | modifiers[7:0], slot_0[15:8] .. slot_5[55:48]  | -
//
// one word per cycle sustained while m_axis_tready holds: the byte is registered,
// decoded combinationally against the held report and the new report lands
// in the output register; a taken byte waits in the input register until
// its report is registered; bytes that change no slot give no word.
// reset (aresetn low, synchronous) empties the report and clears all prefixes.
// a stalled m_axis keeps its word; one more byte waits in the input register,
// then s_axis_tready drops.
`default_nettype none

`include "ps2_set2_to_hid_report_macros.svh"

module ps2_set2_to_hid_report #(
    parameter int KEY_SLOTS = ps2hid_pkg::KEY_SLOTS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // scan_byte[7:0]
    input  wire logic                           s_axis_tuser,  // flush
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [ps2hid_pkg::TDATA_W-1:0]      m_axis_tdata   // modifiers, slot_0..slot_5
);

    localparam int SHOWN = (KEY_SLOTS < ps2hid_pkg::OUT_SLOTS) ?
                           KEY_SLOTS : ps2hid_pkg::OUT_SLOTS;

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_flush_reg;

    logic [7:0]                 mods_reg, mods_next;
    ps2hid_pkg::usage_t         keys_reg  [KEY_SLOTS];
    ps2hid_pkg::usage_t         keys_next [KEY_SLOTS];
    logic                       ext_reg, ext_next;
    logic                       rel_reg, rel_next;
    logic                       pause_reg, pause_next;
    logic                       second_reg, second_next;

    logic                       out_valid_reg;
    logic [ps2hid_pkg::TDATA_W-1:0] out_data_reg;
    logic [ps2hid_pkg::TDATA_W-1:0] report;

    logic                       proc_fire;
    logic                       emit;
    logic                       state_clear;

    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg  <= s_axis_tdata;
            in_flush_reg <= s_axis_tuser;
        end
    end

    // decode one byte against the held report
    always_comb begin
        ps2hid_pkg::usage_t usage;
        logic [7:0]         mbit;
        logic               found;
        logic               held;
        mods_next   = mods_reg;
        keys_next   = keys_reg;
        ext_next    = ext_reg;
        rel_next    = rel_reg;
        pause_next  = pause_reg;
        second_next = second_reg;
        emit        = 1'b0;
        usage       = ext_reg ? ps2hid_pkg::map_extended(in_byte_reg)
                              : ps2hid_pkg::map_base(in_byte_reg);
        mbit        = ps2hid_pkg::modifier_bit(usage);
        found       = 1'b0;
        held        = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (keys_reg[i] == usage) begin
                held = 1'b1;
            end
        end
        if (in_flush_reg) begin
            mods_next   = '0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                keys_next[i] = '0;
            end
            ext_next    = 1'b0;
            rel_next    = 1'b0;
            pause_next  = 1'b0;
            second_next = 1'b0;
        end else begin
            case (in_byte_reg)
                ps2hid_pkg::CODE_BAT_OK: begin
                end
                ps2hid_pkg::CODE_PAUSE: begin
                    pause_next = 1'b1;
                end
                ps2hid_pkg::CODE_EXT: begin
                    ext_next = 1'b1;
                end
                ps2hid_pkg::CODE_BREAK: begin
                    rel_next = 1'b1;
                end
                default: begin
                    ext_next = 1'b0;
                    rel_next = 1'b0;
                    if (pause_reg) begin
                        pause_next  = 1'b0;
                        second_next = 1'b1;
                    end else begin
                        second_next = 1'b0;
                        // second code of a pause sequence does nothing
                        if (!second_reg && usage != 8'h00) begin
                            if (rel_reg) begin
                                mods_next = mods_reg & ~mbit;
                                for (int i = 0; i < KEY_SLOTS; i++) begin
                                    if (!found && keys_reg[i] == usage) begin
                                        found        = 1'b1;
                                        keys_next[i] = 8'h00;
                                    end
                                end
                                emit = found;
                            end else if (!held) begin
                                mods_next = mods_reg | mbit;
                                for (int i = 0; i < KEY_SLOTS; i++) begin
                                    if (!found && keys_reg[i] == 8'h00) begin
                                        found        = 1'b1;
                                        keys_next[i] = usage;
                                    end
                                end
                                emit = found;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        report      = '0;
        report[7:0] = mods_next;
        for (int j = 0; j < SHOWN; j++) begin
            report[8 + 8*j +: 8] = keys_next[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mods_reg   <= '0;
            ext_reg    <= 1'b0;
            rel_reg    <= 1'b0;
            pause_reg  <= 1'b0;
            second_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                keys_reg[i] <= '0;
            end
        end else if (proc_fire) begin
            mods_reg   <= mods_next;
            ext_reg    <= ext_next;
            rel_reg    <= rel_next;
            pause_reg  <= pause_next;
            second_reg <= second_next;
            keys_reg   <= keys_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_fire && emit) begin
            out_data_reg <= report;
        end
    end

    assign state_clear = mods_reg == 8'h00 && !ext_reg && !rel_reg && !pause_reg && !second_reg;

    `PS2HID_ASSERT_NOW(a_flush_silent, aclk, aresetn, proc_fire && in_flush_reg, !emit)
    `PS2HID_ASSERT_NEXT(a_flush_clears, aclk, aresetn, proc_fire && in_flush_reg, state_clear)
    `PS2HID_ASSERT_NEXT(a_emit_shows, aclk, aresetn, proc_fire && emit, m_axis_tvalid)

endmodule

`default_nettype wire

// File: dv/tb.sv
module tb;

    localparam int NUM_SLOTS   = 6;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_TAIL   = 150;

    // scan set 2 code to hid usage, plain page
    localparam logic [7:0] SET2_PLAIN [132] = '{
        8'h00, 8'h42, 8'h00, 8'h3E, 8'h3C, 8'h3A, 8'h3B, 8'h45,
        8'h68, 8'h43, 8'h41, 8'h3F, 8'h3D, 8'h2B, 8'h35, 8'h67,
        8'h69, 8'hE2, 8'hE1, 8'h00, 8'hE0, 8'h14, 8'h1E, 8'h00,
        8'h6A, 8'h00, 8'h1D, 8'h16, 8'h04, 8'h1A, 8'h1F, 8'h00,
        8'h6B, 8'h06, 8'h1B, 8'h07, 8'h08, 8'h21, 8'h20, 8'h00,
        8'h6C, 8'h2C, 8'h19, 8'h09, 8'h17, 8'h15, 8'h22, 8'h00,
        8'h6D, 8'h11, 8'h05, 8'h0B, 8'h0A, 8'h1C, 8'h23, 8'h00,
        8'h6E, 8'h00, 8'h10, 8'h0D, 8'h18, 8'h24, 8'h25, 8'h00,
        8'h6F, 8'h36, 8'h0E, 8'h0C, 8'h12, 8'h27, 8'h26, 8'h00,
        8'h70, 8'h37, 8'h38, 8'h0F, 8'h33, 8'h13, 8'h2D, 8'h00,
        8'h71, 8'h00, 8'h34, 8'h00, 8'h2F, 8'h2E, 8'h00, 8'h72,
        8'h39, 8'hE5, 8'h28, 8'h30, 8'h00, 8'h32, 8'h00, 8'h73,
        8'h00, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2A, 8'h00,
        8'h00, 8'h59, 8'h00, 8'h5C, 8'h5F, 8'h00, 8'h00, 8'h00,
        8'h62, 8'h63, 8'h5A, 8'h5D, 8'h5E, 8'h60, 8'h29, 8'h53,
        8'h44, 8'h57, 8'h5B, 8'h56, 8'h55, 8'h61, 8'h47, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h40
    };

    // keys used most of the time so that slots fill up and releases hit
    localparam logic [7:0] HOT_CODE [16] = '{
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h12, 8'h14, 8'h11, 8'h59,
        8'h14, 8'h11, 8'h1F, 8'h27, 8'h75, 8'h6B, 8'h83, 8'h76
    };
    localparam logic [15:0] HOT_EXT = 16'b0011_1111_0000_0000;

    localparam logic [7:0] PAUSE_KEY_SEQ [8] = '{
        ps2hid_pkg::CODE_PAUSE, 8'h14, 8'h77, ps2hid_pkg::CODE_PAUSE,
        ps2hid_pkg::CODE_BREAK, 8'h14, ps2hid_pkg::CODE_BREAK, 8'h77
    };

    localparam logic [7:0] OPENING [25] = '{
        8'h00, 8'hFF, 8'h83, 8'h1C, ps2hid_pkg::CODE_EXT, 8'h75, 8'h12, 8'h59, 8'h14,
        8'h1B, 8'h1C, ps2hid_pkg::CODE_BREAK, 8'h1B,
        ps2hid_pkg::CODE_EXT, ps2hid_pkg::CODE_EXT,
        ps2hid_pkg::CODE_BREAK, ps2hid_pkg::CODE_BREAK, 8'h75,
        ps2hid_pkg::CODE_PAUSE, ps2hid_pkg::CODE_BREAK, 8'h14, 8'h77,
        ps2hid_pkg::CODE_BAT_OK, ps2hid_pkg::CODE_BREAK, 8'h1C
    };

    typedef enum int {
        SEQ_PRESS, SEQ_RELEASE, SEQ_PAUSE, SEQ_BAT, SEQ_FLUSH, SEQ_NOISE
    } seq_kind_t;

    typedef struct {
        logic [7:0] code;
        logic       flush;
        bit         drain;
    } scan_item_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [ps2hid_pkg::TDATA_W-1:0]  m_axis_tdata;

    ps2_set2_to_hid_report #(.KEY_SLOTS(NUM_SLOTS)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // scan_byte[7:0]
        .s_axis_tuser  (s_axis_tuser),   // flush
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // modifiers, slot_0 .. slot_5
    );

    scan_item_t          scan_q[$];
    logic [ps2hid_pkg::TDATA_W-1:0]  report_q[$];

    // predicted keyboard state
    logic [7:0] held_mods;
    ps2hid_pkg::usage_t held_usage [NUM_SLOTS];
    bit         ext_pending, brk_pending, in_pause, pause_tail;

    int mismatches;
    int reports_seen;
    int tx_gap, drain_settle, rx_gap, long_hold_left, idle_cycles;
    bit long_hold_done, calm;
    scan_item_t next_item;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic ps2hid_pkg::usage_t set2_ext_usage(input logic [7:0] code);
        case (code)
            8'h11: return 8'hE6;
            8'h1F: return 8'hE3;
            8'h14: return 8'hE4;
            8'h27: return 8'hE7;
            8'h4A: return 8'h54;
            8'h5A: return 8'h58;
            8'h69: return 8'h4D;
            8'h6B: return 8'h50;
            8'h6C: return 8'h4A;
            8'h7C: return 8'h46;
            8'h70: return 8'h49;
            8'h71: return 8'h4C;
            8'h72: return 8'h51;
            8'h74: return 8'h4F;
            8'h75: return 8'h52;
            8'h7A: return 8'h4E;
            8'h7D: return 8'h4B;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] mod_mask(input ps2hid_pkg::usage_t u);
        return (u >= 8'hE0 && u <= 8'hE7) ? (8'h01 << u[2:0]) : 8'h00;
    endfunction

    task automatic queue_report();
        logic [ps2hid_pkg::TDATA_W-1:0] w;
        w = '0;
        w[7:0] = held_mods;
        for (int j = 0; j < ps2hid_pkg::OUT_SLOTS; j++) begin
            if (j < NUM_SLOTS) w[8*(j+1) +: 8] = held_usage[j];
        end
        report_q.push_back(w);
    endtask

    task automatic press_usage(input ps2hid_pkg::usage_t u);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (held_usage[i] == u) return;
        end
        held_mods |= mod_mask(u);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (held_usage[i] == 8'h00) begin
                held_usage[i] = u;
                queue_report();
                return;
            end
        end
    endtask

    task automatic release_usage(input ps2hid_pkg::usage_t u);
        held_mods &= ~mod_mask(u);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (held_usage[i] == u) begin
                held_usage[i] = 8'h00;
                queue_report();
                return;
            end
        end
    endtask

    task automatic clear_keyboard();
        held_mods = 8'h00;
        foreach (held_usage[i]) held_usage[i] = 8'h00;
        ext_pending = 1'b0;
        brk_pending = 1'b0;
        in_pause = 1'b0;
        pause_tail = 1'b0;
    endtask

    // advance the predicted keyboard by one accepted byte
    task automatic track_scan(input logic [7:0] code, input logic flush);
        ps2hid_pkg::usage_t u;
        if (flush) begin
            clear_keyboard();
            return;
        end
        case (code)
            ps2hid_pkg::CODE_BAT_OK: ;
            ps2hid_pkg::CODE_PAUSE:  in_pause = 1'b1;
            ps2hid_pkg::CODE_EXT:    ext_pending = 1'b1;
            ps2hid_pkg::CODE_BREAK:  brk_pending = 1'b1;
            default: begin
                if (in_pause) begin
                    in_pause = 1'b0;
                    pause_tail = 1'b1;
                end else begin
                    if (!pause_tail) begin
                        u = ext_pending ? set2_ext_usage(code)
                                        : (code < 8'd132 ? SET2_PLAIN[code] : 8'h00);
                        if (u != 8'h00) begin
                            if (brk_pending) release_usage(u);
                            else press_usage(u);
                        end
                    end
                    pause_tail = 1'b0;
                end
                ext_pending = 1'b0;
                brk_pending = 1'b0;
            end
        endcase
    endtask

    task automatic check_report(input logic [ps2hid_pkg::TDATA_W-1:0] got);
        logic [ps2hid_pkg::TDATA_W-1:0] want;
        if (report_q.size() == 0) begin
            note_mismatch($sformatf("report %h with none expected", got));
            return;
        end
        want = report_q.pop_front();
        if (got[7:0] !== want[7:0])
            note_mismatch($sformatf("modifiers %h, expected %h", got[7:0], want[7:0]));
        for (int f = 0; f < ps2hid_pkg::OUT_SLOTS; f++) begin
            if (got[8*(f+1) +: 8] !== want[8*(f+1) +: 8])
                note_mismatch($sformatf("slot_%0d %h, expected %h", f,
                                        got[8*(f+1) +: 8], want[8*(f+1) +: 8]));
        end
    endtask

    task automatic push_scan(input logic [7:0] code, input logic flush, input bit drain);
        scan_item_t it;
        it.code = code;
        it.flush = flush;
        it.drain = drain;
        scan_q.push_back(it);
    endtask

    task automatic push_key(input bit is_release, input bit drain);
        int k;
        logic [7:0] code;
        bit ext;
        if ($urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, 15);
            code = HOT_CODE[k];
            ext = HOT_EXT[k];
        end else begin
            code = 8'($urandom_range(0, 255));
            ext = 1'($urandom_range(0, 1));
        end
        if (ext) begin
            push_scan(ps2hid_pkg::CODE_EXT, 1'b0, drain);
            drain = 1'b0;
        end
        if (is_release) begin
            push_scan(ps2hid_pkg::CODE_BREAK, 1'b0, drain);
            drain = 1'b0;
        end
        push_scan(code, 1'b0, drain);
    endtask

    task automatic fill_random();
        int r;
        int start;
        bit drain;
        bit mid_drain_done;
        seq_kind_t kind;
        start = scan_q.size();
        drain = 1'b1;
        mid_drain_done = 1'b0;
        while (scan_q.size() - start < RANDOM_ITEMS) begin
            if (!mid_drain_done && scan_q.size() - start > RANDOM_ITEMS / 2) begin
                drain = 1'b1;
                mid_drain_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45)      kind = SEQ_PRESS;
            else if (r < 80) kind = SEQ_RELEASE;
            else if (r < 85) kind = SEQ_PAUSE;
            else if (r < 88) kind = SEQ_BAT;
            else if (r < 90) kind = SEQ_FLUSH;
            else             kind = SEQ_NOISE;
            case (kind)
                SEQ_PRESS:   push_key(1'b0, drain);
                SEQ_RELEASE: push_key(1'b1, drain);
                SEQ_PAUSE: begin
                    foreach (PAUSE_KEY_SEQ[i]) push_scan(PAUSE_KEY_SEQ[i], 1'b0, drain && i == 0);
                end
                SEQ_BAT:     push_scan(ps2hid_pkg::CODE_BAT_OK, 1'b0, drain);
                SEQ_FLUSH:   push_scan(8'($urandom_range(0, 255)), 1'b1, drain);
                default:     push_scan(8'($urandom_range(0, 255)), 1'b0, drain);
            endcase
            drain = 1'b0;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            clear_keyboard();
        end else begin
            if (s_axis_tvalid && s_axis_tready) track_scan(s_axis_tdata, s_axis_tuser);
            calm = scan_q.size() < CALM_TAIL;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (scan_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (scan_q[0].drain && drain_settle < 8) begin
                    // hold until every outstanding report has been taken
                    drain_settle = (report_q.size() != 0) ? 0 : drain_settle + 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!calm && long_hold_left == 0 && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_item = scan_q.pop_front();
                    drain_settle = 0;
                    s_axis_tdata <= next_item.code;
                    s_axis_tuser <= next_item.flush;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_report(m_axis_tdata);
                reports_seen++;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && reports_seen >= 100) begin
                // long back-pressure so the input side has to stall
                long_hold_done = 1'b1;
                long_hold_left = 79;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (OPENING[i]) push_scan(OPENING[i], 1'b0, 1'b0);
        push_scan(8'h1C, 1'b1, 1'b0);
        push_scan(ps2hid_pkg::CODE_EXT, 1'b0, 1'b0);
        push_scan(8'h27, 1'b0, 1'b0);
        fill_random();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (scan_q.size() != 0 || s_axis_tvalid);
        while (report_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (report_q.size() != 0) note_mismatch("reports never delivered");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
